>>> sv/vac_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vac_pkg;

  localparam int unsigned CalSamplesDef = 64;

  localparam int unsigned ThrW     = 15;
  localparam int unsigned KeyW     = 3;
  localparam int unsigned LevelW   = 12;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 15;

  localparam logic [ThrW-1:0] ThrRst    = 15'd100;
  localparam logic [ThrW-1:0] MinThrRst = 15'd30;
  localparam logic [ThrW-1:0] ThrMax    = 15'h7fff;

  typedef enum logic [KeyW-1:0] {
    KEY_NONE   = 3'd0,
    KEY_SELECT = 3'd1,
    KEY_LEFT   = 3'd2,
    KEY_RIGHT  = 3'd3,
    KEY_UP     = 3'd4,
    KEY_DOWN   = 3'd5
  } key_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_THR_START = 2'd0,
    CFG_MIN_THR   = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
    logic [LevelW-1:0]  key_level;
  } in_t;

  typedef struct packed {
    logic               buzzer;
    logic               display_on;
    logic               alarm_latched;
    logic               menu_active;
    logic               calibrating;
    logic               chirp;
    logic [ThrW-1:0]    threshold;
    logic signed [15:0] corrected_x;
    logic signed [15:0] corrected_y;
    logic signed [15:0] corrected_z;
    key_e               key_code;
  } out_t;

  // calibration status handed to the control logic
  typedef struct packed {
    logic               calibrating;
    logic               div_busy;
    logic signed [15:0] offset_x;
    logic signed [15:0] offset_y;
    logic signed [15:0] offset_z;
  } cal_stat_t;

  // ladder windows, tested in priority order
  function automatic key_e decode_key(logic [LevelW-1:0] lv);
    key_e k;
    if (lv inside {[12'd2401:12'd2699]}) begin
      k = KEY_SELECT;
    end else if (lv inside {[12'd1601:12'd1999]}) begin
      k = KEY_LEFT;
    end else if (lv inside {[12'd401:12'd799]}) begin
      k = KEY_UP;
    end else if (lv inside {[12'd1001:12'd1299]}) begin
      k = KEY_DOWN;
    end else if (lv < 12'd300) begin
      k = KEY_RIGHT;
    end else begin
      k = KEY_NONE;
    end
    return k;
  endfunction

endpackage

`default_nettype wire

>>> sv/vac_calib.sv
`timescale 1ns / 1ps
`default_nettype none

module vac_calib #(
  parameter int unsigned CalSamples = vac_pkg::CalSamplesDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  vac_pkg::in_t           item_i,
  output vac_pkg::cal_stat_t     stat_o
);
  import vac_pkg::*;

  localparam int unsigned CntW  = $clog2(CalSamples + 1);
  localparam int unsigned Cb    = $clog2(CalSamples);
  localparam int unsigned AccW  = 16 + Cb;
  localparam int unsigned K     = AccW + Cb;
  localparam int unsigned MulW  = AccW + 2;
  localparam int unsigned ProdW = AccW + MulW;

  // ceil(2^K / n) gives an exact floor division for every biased sum
  localparam longint unsigned RecipL =
    ((64'd1 << K) + 64'(CalSamples) - 64'd1) / 64'(CalSamples);
  localparam logic [MulW-1:0] Recip = RecipL[MulW-1:0];
  // n * 32768 lifts every sum to a non-negative value
  localparam logic [AccW-1:0] Bias     = AccW'(64'(CalSamples) * 64'd32768);
  localparam logic [CntW-1:0] CntLast  = CntW'(CalSamples - 1);
  localparam logic [CntW-1:0] CntFull  = CntW'(CalSamples);

  logic [CntW-1:0]        cnt_q;
  logic                   busy_q;
  logic signed [AccW-1:0] acc_q [3];
  logic signed [15:0]     off_q [3];
  logic signed [15:0]     off_d [3];
  logic signed [15:0]     smp   [3];
  logic [AccW-1:0]        biased [3];
  logic [ProdW-1:0]       prod  [3];
  logic [15:0]            quot  [3];
  logic                   cal;

  assign cal = (cnt_q < CntFull);

  always_comb begin
    smp[0] = item_i.gyro_x;
    smp[1] = item_i.gyro_y;
    smp[2] = item_i.gyro_z;
    for (int a = 0; a < 3; a++) begin
      biased[a] = unsigned'(acc_q[a]) + Bias;
      prod[a]   = {{MulW{1'b0}}, biased[a]} * {{AccW{1'b0}}, Recip};
      quot[a]   = prod[a][K+15:K];
      // remove the bias of 32768 again
      off_d[a]  = signed'({~quot[a][15], quot[a][14:0]});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        acc_q[a] <= '0;
        off_q[a] <= '0;
      end
    end else begin
      if (step_i && cal) begin
        for (int a = 0; a < 3; a++) begin
          acc_q[a] <= acc_q[a] + AccW'(smp[a]);
        end
        cnt_q  <= cnt_q + 1'b1;
        busy_q <= (cnt_q == CntLast);
      end else begin
        busy_q <= 1'b0;
      end
      if (busy_q) begin
        for (int a = 0; a < 3; a++) begin
          off_q[a] <= off_d[a];
        end
      end
    end
  end

  always_comb begin
    stat_o.calibrating = cal;
    stat_o.div_busy    = busy_q;
    stat_o.offset_x    = off_q[0];
    stat_o.offset_y    = off_q[1];
    stat_o.offset_z    = off_q[2];
  end

endmodule

`default_nettype wire

>>> sv/vac_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module vac_ctrl (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         step_i,
  input  vac_pkg::in_t                      item_i,
  input  vac_pkg::cal_stat_t                cal_i,
  input  wire logic                         cfg_we_i,
  input  wire logic [vac_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [vac_pkg::CfgDataW-1:0] cfg_data_i,
  output vac_pkg::out_t                     result_o
);
  import vac_pkg::*;

  logic            alarm_q, alarm_d;
  logic            menu_q, menu_d;
  logic            buzz_q, buzz_d;
  logic            disp_q, disp_d;
  logic [ThrW-1:0] thr_q, thr_d;
  logic [ThrW-1:0] min_thr_q;
  logic            chirp;
  logic            hit;
  key_e            key;
  logic signed [15:0] raw  [3];
  logic signed [15:0] off  [3];
  logic signed [15:0] corr [3];
  logic signed [16:0] c17  [3];
  logic signed [16:0] t17;

  always_comb begin
    key    = decode_key(item_i.key_level);
    raw[0] = item_i.gyro_x;
    raw[1] = item_i.gyro_y;
    raw[2] = item_i.gyro_z;
    off[0] = cal_i.offset_x;
    off[1] = cal_i.offset_y;
    off[2] = cal_i.offset_z;
    t17    = signed'({2'b00, thr_q});
    hit    = 1'b0;
    for (int a = 0; a < 3; a++) begin
      corr[a] = cal_i.calibrating ? 16'sd0 : (raw[a] - off[a]);
      c17[a]  = {corr[a][15], corr[a]};
      if ((c17[a] > t17) || (c17[a] < -t17)) begin
        hit = 1'b1;
      end
    end

    alarm_d = alarm_q;
    menu_d  = menu_q;
    buzz_d  = buzz_q;
    disp_d  = disp_q;
    thr_d   = thr_q;
    chirp   = 1'b0;

    if (!cal_i.calibrating) begin
      if (!alarm_q && hit) begin
        alarm_d = 1'b1;
        buzz_d  = 1'b1;
        disp_d  = 1'b1;
      end
      case (key)
        KEY_RIGHT: begin
          if (alarm_d) begin
            alarm_d = 1'b0;
            buzz_d  = 1'b0;
            disp_d  = 1'b0;
          end
        end
        KEY_SELECT: begin
          if (!menu_q) begin
            chirp   = 1'b1;
            buzz_d  = 1'b0;
            alarm_d = 1'b1;
            menu_d  = 1'b1;
            disp_d  = 1'b1;
          end
        end
        KEY_UP: begin
          if (menu_q && (thr_q != ThrMax)) begin
            thr_d = thr_q + 1'b1;
          end
        end
        KEY_DOWN: begin
          if (menu_q && (thr_q > min_thr_q)) begin
            thr_d = thr_q - 1'b1;
          end
        end
        KEY_LEFT: begin
          if (menu_q) begin
            alarm_d = 1'b0;
            menu_d  = 1'b0;
            disp_d  = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end

    result_o.buzzer        = buzz_d;
    result_o.display_on    = disp_d;
    result_o.alarm_latched = alarm_d;
    result_o.menu_active   = menu_d;
    result_o.calibrating   = cal_i.calibrating;
    result_o.chirp         = chirp;
    result_o.threshold     = thr_d;
    result_o.corrected_x   = corr[0];
    result_o.corrected_y   = corr[1];
    result_o.corrected_z   = corr[2];
    result_o.key_code      = key;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alarm_q   <= 1'b0;
      menu_q    <= 1'b0;
      buzz_q    <= 1'b0;
      disp_q    <= 1'b0;
      thr_q     <= ThrRst;
      min_thr_q <= MinThrRst;
    end else begin
      if (step_i) begin
        alarm_q <= alarm_d;
        menu_q  <= menu_d;
        buzz_q  <= buzz_d;
        disp_q  <= disp_d;
      end
      // a start value write reloads the threshold
      if (cfg_we_i && (cfg_idx_e'(cfg_index_i) == CFG_THR_START)) begin
        thr_q <= cfg_data_i;
      end else if (step_i) begin
        thr_q <= thr_d;
      end
      if (cfg_we_i && (cfg_idx_e'(cfg_index_i) == CFG_MIN_THR)) begin
        min_thr_q <= cfg_data_i;
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/vibration_alarm_controller.sv
// data path: input register, then processing into the result register
// throughput: one word per cycle without output stalls, but a bubble straight after the
//   last calibration word while the offset multipliers load the axis offsets
// reset: rst_ni is asynchronous, active low; it empties both stages, clears the
//   calibration count, sums, offsets and alarm/menu flags, and loads the default
//   threshold (100) and minimum threshold (30)
`timescale 1ns / 1ps
`default_nettype none

module vibration_alarm_controller #(
  parameter int unsigned CalSamples = vac_pkg::CalSamplesDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // sample words
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  vac_pkg::in_t                      in_data_i,
  // result words
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output vac_pkg::out_t                     out_data_o,
  // register writes
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [vac_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [vac_pkg::CfgDataW-1:0] cfg_data_i
);
  import vac_pkg::*;

  logic      in_vld_q;
  in_t       in_data_q;
  logic      out_vld_q;
  out_t      out_data_q;
  logic      out_free;
  logic      step;
  logic      cfg_we;
  cal_stat_t cal_stat;
  out_t      result;

  // output register can take a word when empty or being drained
  assign out_free = !out_vld_q || !out_stall_i;
  // the held word is processed when the output register is free and the offsets are not being loaded
  assign step     = in_vld_q && out_free && !cal_stat.div_busy;

  assign in_stall_o  = in_vld_q && !step;
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_vld_q <= 1'b1;
    end else if (step) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_data_q <= in_data_i;
    end
  end

  // offset calibration: sums, sample count and the floor-mean multipliers
  vac_calib #(
    .CalSamples (CalSamples)
  ) u_calib (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_data_q),
    .stat_o (cal_stat)
  );

  // offset removal, threshold detection, key decode and menu flags
  vac_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (in_data_q),
    .cal_i       (cal_stat),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .result_o    (result)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_data_q;

  // a select chirp always leaves the menu open, the alarm set and the buzzer quiet
  a_chirp_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_data_q.chirp) |->
      (out_data_q.menu_active && out_data_q.alarm_latched && !out_data_q.buzzer))
    else $error("chirp without menu entry state");

  // offset load lasts one cycle and follows a calibration step
  a_busy_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cal_stat.div_busy |=> !cal_stat.div_busy)
    else $error("offset load longer than one cycle");

  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(cal_stat.div_busy) |-> ($past(step) && $past(cal_stat.calibrating)))
    else $error("offset load without a calibration word");

  // calibration words report zero corrected values
  a_cal_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && result.calibrating) |->
      ((result.corrected_x == 16'sd0) && (result.corrected_y == 16'sd0) &&
       (result.corrected_z == 16'sd0)))
    else $error("corrected value during calibration");

endmodule

`default_nettype wire
